FILE: rtl/deq_pkg.sv
// Shared types and codes for the indexed double-ended queue.
package deq_pkg;

    // Field widths of one item and one result.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Result bookkeeping that travels from the controller to the output stage.
    typedef struct packed {
        logic                rd;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } deq_meta_t;

endpackage

FILE: rtl/deq_ram.sv
// Slot memory: one write port and one read port with registered read data.
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int PW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [PW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data is registered and valid in the cycle after the request.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/deq_ctrl.sv
// Pointer and count control: decodes an item into a memory access and a status.
module deq_ctrl #(
    parameter int DEPTH = 16,
    parameter int PW    = 4,
    parameter int CW    = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [deq_pkg::ACTION_W-1:0]   action,
    input  logic [deq_pkg::VALUE_W-1:0]    value,
    input  logic [deq_pkg::POS_W-1:0]      position,
    output logic                           mem_wr_en,
    output logic                           mem_rd_en,
    output logic [PW-1:0]                  mem_addr,
    output logic [31:0]                    mem_wr_data,
    output deq_pkg::deq_meta_t             meta
);
    import deq_pkg::*;

    // Wide enough for the count, the position and the occupancy field.
    localparam int CMPW = (CW > OCC_W) ? CW : OCC_W;

    logic [PW-1:0]   bp_reg, bp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   cnt_m1;
    logic [CMPW-1:0] cnt_x, cnt_m1_x, pos_x, cnt_next_x;
    logic            full, empty, in_range;
    logic [PW-1:0]   bp_dec, bp_inc;
    logic            wr, rd;
    logic [STATUS_W-1:0] status;

    // Ring index of an offset from position 0.
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(DEPTH)) begin
            sum = sum - (PW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // Condition flags and neighbor pointers.
    always_comb begin
        cnt_m1   = cnt_reg - 1'b1;
        cnt_x    = CMPW'(cnt_reg);
        cnt_m1_x = CMPW'(cnt_m1);
        pos_x    = CMPW'(position);
        full     = (cnt_reg == CW'(DEPTH));
        empty    = (cnt_reg == '0);
        in_range = (pos_x < cnt_x);
        bp_dec   = (bp_reg == '0) ? PW'(DEPTH - 1) : bp_reg - 1'b1;
        bp_inc   = (bp_reg == PW'(DEPTH - 1)) ? '0 : bp_reg + 1'b1;
    end

    // Action decode.
    always_comb begin
        wr       = 1'b0;
        rd       = 1'b0;
        mem_addr = bp_reg;
        status   = ST_OK;
        bp_next  = bp_reg;
        cnt_next = cnt_reg;
        unique case (action)
            ACT_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    wr       = 1'b1;
                    mem_addr = ring_add(bp_reg, cnt_x[PW-1:0]);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    wr       = 1'b1;
                    mem_addr = bp_dec;
                    bp_next  = bp_dec;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd       = 1'b1;
                    mem_addr = ring_add(bp_reg, cnt_m1_x[PW-1:0]);
                    cnt_next = cnt_m1;
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd       = 1'b1;
                    mem_addr = bp_reg;
                    bp_next  = bp_inc;
                    cnt_next = cnt_m1;
                end
            end
            ACT_READ: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    rd       = 1'b1;
                    mem_addr = ring_add(bp_reg, pos_x[PW-1:0]);
                end
            end
            ACT_WRITE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    wr       = 1'b1;
                    mem_addr = ring_add(bp_reg, pos_x[PW-1:0]);
                end
            end
            default: begin
                // Unused codes leave the queue untouched.
            end
        endcase
        cnt_next_x = CMPW'(cnt_next);
    end

    assign mem_wr_en      = accept && wr;
    assign mem_rd_en      = accept && rd;
    assign mem_wr_data    = value;
    assign meta.rd        = rd;
    assign meta.status    = status;
    assign meta.occupancy = cnt_next_x[OCC_W-1:0];

    // Pointer and count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg  <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            bp_reg  <= bp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/double_ended_queue_indexed_top.sv
// Top level of the indexed double-ended queue with stream ports.
// A result passes through the memory read and then the output register before it can be taken.
// Throughput: one item per cycle while results are taken; the slot memory's
// registered read port holds one result in flight ahead of the output register.
// Reset clears the back pointer, the element count and both valid flags; the
// slot memory is not cleared and needs no clearing pass.
module double_ended_queue_indexed_top #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action [2:0], value [34:3], position [38:35], zero pad [39]
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data_out [31:0], status [33:32], occupancy [38:34], zero pad [39]
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                accept, out_load;
    logic                mem_wr_en, mem_rd_en;
    logic [PW-1:0]       mem_addr;
    logic [31:0]         mem_wr_data, mem_rd_data;
    deq_meta_t           meta, meta_reg;
    logic                pending_reg, pending_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]  m_data_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [OCC_W-1:0]    m_occ_reg;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .action      (s_tdata[2:0]),
        .value       (s_tdata[34:3]),
        .position    (s_tdata[38:35]),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .meta        (meta)
    );

    deq_ram #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    // Handshake: a new item enters when no result is in flight or when the in-flight result moves out.
    always_comb begin
        out_load      = pending_reg && (!m_tvalid_reg || m_tready);
        s_tready      = !pending_reg || out_load;
        accept        = s_tvalid && s_tready;
        pending_next  = accept ? 1'b1 : (out_load ? 1'b0 : pending_reg);
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pending_reg  <= pending_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result bookkeeping for the item in flight, and the output register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            meta_reg <= meta;
        end
        if (out_load) begin
            m_data_reg   <= meta_reg.rd ? mem_rd_data : '0;
            m_status_reg <= meta_reg.status;
            m_occ_reg    <= meta_reg.occupancy;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_occ_reg, m_status_reg, m_data_reg};

`ifndef SYNTHESIS
    // An accepted item always leaves a result in flight.
    a_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> pending_reg)
        else $error("accepted item did not leave a result in flight");

    // A result moved to the output is offered in the next cycle.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("loaded result not offered");

    // A failed action returns zero data.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("failed action returned nonzero data");

    // An empty pop reports an empty queue.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] == ST_EMPTY) |-> (m_tdata[38:34] == '0))
        else $error("empty status with nonzero occupancy");
`endif

endmodule
